/* rtl/efd_pkg.sv */
// Shared constants, codes and types for the elevator floor dispatcher.
package efd_pkg;

    localparam int MAX_FLOORS = 32;
    localparam int FLOOR_W    = 6;
    localparam int SCAN_W     = FLOOR_W + 1;
    localparam int IDX_W      = (MAX_FLOORS > 1) ? $clog2(MAX_FLOORS) : 1;
    localparam int OP_W       = 2;
    localparam int DIR_W      = 2;
    localparam int IN_W       = 8;
    localparam int OUT_W      = 24;

    localparam logic [FLOOR_W-1:0] COUNT_RST = FLOOR_W'(32);
    localparam logic [FLOOR_W-1:0] FLOOR_RST = FLOOR_W'(1);

    localparam logic [DIR_W-1:0] DIR_STAND = 2'd0;
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_REQUEST   = 2'd0,
        OP_STOP      = 2'd1,
        OP_POSITION  = 2'd2,
        OP_DIRECTION = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_INIT_A,
        ST_SCAN_A,
        ST_INIT_B,
        ST_SCAN_B,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic apply;
        logic init_a;
        logic init_b;
        logic step;
        logic finish;
    } efd_cmd_t;

    typedef struct packed {
        logic need_pick;
        logic scan_done;
        logic out_free;
    } efd_stat_t;

endpackage

/* rtl/efd_ctrl.sv */
// Controller state machine sequencing event apply, two scan passes and result issue.
module efd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  efd_pkg::efd_stat_t stat,
    output efd_pkg::efd_cmd_t  cmd
);
    import efd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                state_next = stat.need_pick ? ST_INIT_A : ST_FINISH;
            end
            ST_INIT_A:
            begin
                state_next = ST_SCAN_A;
            end
            ST_SCAN_A:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_INIT_B;
                end
            end
            ST_INIT_B:
            begin
                state_next = ST_SCAN_B;
            end
            ST_SCAN_B:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_APPLY:
            begin
                cmd.apply = 1'b1;
            end
            ST_INIT_A:
            begin
                cmd.init_a = 1'b1;
            end
            ST_SCAN_A:
            begin
                cmd.step = 1'b1;
            end
            ST_INIT_B:
            begin
                cmd.init_b = 1'b1;
            end
            ST_SCAN_B:
            begin
                cmd.step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = stat.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/efd_dp.sv */
// Datapath: dispatcher state, serial floor scanner and output word register.
module efd_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [efd_pkg::FLOOR_W-1:0]   cfg_wdata,
    input  logic [efd_pkg::IN_W-1:0]      s_tdata,
    input  logic [efd_pkg::OP_W-1:0]      s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [efd_pkg::OUT_W-1:0]     m_tdata,
    input  efd_pkg::efd_cmd_t             cmd,
    output efd_pkg::efd_stat_t            stat
);
    import efd_pkg::*;

    logic [FLOOR_W-1:0]    count_reg;
    logic [MAX_FLOORS-1:0] map_reg;
    logic [FLOOR_W-1:0]    present_reg;
    logic [FLOOR_W-1:0]    goal_reg;
    logic [DIR_W-1:0]      moving_reg;
    logic                  processing_reg;

    op_t                   op_reg;
    logic [FLOOR_W-1:0]    fl_reg;
    logic [DIR_W-1:0]      dir_reg;

    logic                  pick_reg;
    logic                  stop_reg;
    logic                  bad_reg;

    logic [SCAN_W-1:0]     scan_reg;
    logic                  pass_up_reg;
    logic                  pass_b_reg;
    logic                  nearest_reg;
    logic                  a_hit_reg;
    logic                  b_hit_reg;
    logic [FLOOR_W-1:0]    a_floor_reg;
    logic [FLOOR_W-1:0]    b_floor_reg;

    logic                  m_valid_reg;
    logic [OUT_W-1:0]      m_data_reg;

    logic [SCAN_W-1:0]     eff_n;
    logic                  fl_ok;
    logic [FLOOR_W-1:0]    fl_m1;
    logic [FLOOR_W-1:0]    goal_m1;
    logic                  goal_in_map;
    logic [SCAN_W-1:0]     scan_m1;
    logic                  below_n;
    logic                  in_range;
    logic                  req_hit;
    logic                  found;
    logic [FLOOR_W-1:0]    pick_floor;
    logic [FLOOR_W-1:0]    dist_lo;
    logic [FLOOR_W-1:0]    dist_hi;
    logic                  tv;
    logic [FLOOR_W-1:0]    target;
    logic                  busy;
    logic [FLOOR_W-1:0]    served;
    logic                  going_idle;

    always_comb
    begin
        if (count_reg == '0)
        begin
            eff_n = SCAN_W'(1);
        end
        else if ({1'b0, count_reg} > SCAN_W'(MAX_FLOORS))
        begin
            eff_n = SCAN_W'(MAX_FLOORS);
        end
        else
        begin
            eff_n = {1'b0, count_reg};
        end
    end

    assign fl_ok       = (fl_reg != '0) && ({1'b0, fl_reg} <= eff_n);
    assign fl_m1       = fl_reg - FLOOR_W'(1);
    assign goal_m1     = goal_reg - FLOOR_W'(1);
    assign goal_in_map = (goal_reg != '0) && ({1'b0, goal_reg} <= SCAN_W'(MAX_FLOORS));

    assign scan_m1  = scan_reg - SCAN_W'(1);
    assign below_n  = (scan_reg <= eff_n);
    assign in_range = (scan_reg != '0) && (below_n || (nearest_reg && !pass_up_reg));
    assign req_hit  = in_range && below_n && map_reg[scan_m1[IDX_W-1:0]];

    assign dist_lo = present_reg - a_floor_reg;
    assign dist_hi = b_floor_reg - present_reg;
    assign found   = a_hit_reg || b_hit_reg;

    always_comb
    begin
        if (nearest_reg && a_hit_reg && b_hit_reg)
        begin
            pick_floor = (dist_lo < dist_hi) ? a_floor_reg : b_floor_reg;
        end
        else
        begin
            pick_floor = a_hit_reg ? a_floor_reg : b_floor_reg;
        end
    end

    assign going_idle = stop_reg && !found;
    assign tv         = pick_reg && ((op_reg == OP_REQUEST) || found);
    assign target     = (pick_reg && found) ? pick_floor : goal_reg;
    assign busy       = going_idle ? 1'b0 : processing_reg;
    assign served     = stop_reg ? present_reg : '0;

    assign stat.need_pick = ((op_reg == OP_REQUEST) && fl_ok)
                          || ((op_reg == OP_STOP) && processing_reg);
    assign stat.scan_done = !in_range || req_hit;
    assign stat.out_free  = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= COUNT_RST;
            map_reg        <= '0;
            present_reg    <= FLOOR_RST;
            goal_reg       <= FLOOR_RST;
            moving_reg     <= DIR_STAND;
            processing_reg <= 1'b0;
            op_reg         <= OP_REQUEST;
            pick_reg       <= 1'b0;
            stop_reg       <= 1'b0;
            bad_reg        <= 1'b0;
            pass_up_reg    <= 1'b0;
            pass_b_reg     <= 1'b0;
            nearest_reg    <= 1'b0;
            a_hit_reg      <= 1'b0;
            b_hit_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end

            if (cmd.capture)
            begin
                op_reg   <= op_t'(s_tuser);
                pick_reg <= 1'b0;
                stop_reg <= 1'b0;
                bad_reg  <= 1'b0;
            end

            if (cmd.apply)
            begin
                case (op_reg)
                    OP_REQUEST:
                    begin
                        if (fl_ok)
                        begin
                            processing_reg                <= 1'b1;
                            map_reg[fl_m1[IDX_W-1:0]]     <= 1'b1;
                            pick_reg                      <= 1'b1;
                        end
                        else
                        begin
                            bad_reg <= 1'b1;
                        end
                    end
                    OP_STOP:
                    begin
                        if (processing_reg)
                        begin
                            present_reg <= goal_reg;
                            if (goal_in_map)
                            begin
                                map_reg[goal_m1[IDX_W-1:0]] <= 1'b0;
                            end
                            stop_reg <= 1'b1;
                            pick_reg <= 1'b1;
                        end
                    end
                    OP_POSITION:
                    begin
                        if (fl_ok)
                        begin
                            present_reg <= fl_reg;
                        end
                        else
                        begin
                            bad_reg <= 1'b1;
                        end
                    end
                    OP_DIRECTION:
                    begin
                        moving_reg <= (dir_reg == DIR_UP || dir_reg == DIR_DOWN)
                                    ? dir_reg : DIR_STAND;
                    end
                    default:
                    begin
                        bad_reg <= 1'b0;
                    end
                endcase
            end

            if (cmd.init_a)
            begin
                nearest_reg <= (moving_reg == DIR_STAND);
                pass_up_reg <= (moving_reg != DIR_STAND) && (moving_reg != DIR_DOWN);
                pass_b_reg  <= 1'b0;
                a_hit_reg   <= 1'b0;
                b_hit_reg   <= 1'b0;
            end

            if (cmd.init_b)
            begin
                pass_up_reg <= !pass_up_reg;
                pass_b_reg  <= 1'b1;
            end

            if (cmd.step && req_hit)
            begin
                if (pass_b_reg)
                begin
                    b_hit_reg <= 1'b1;
                end
                else
                begin
                    a_hit_reg <= 1'b1;
                end
            end

            if (cmd.finish)
            begin
                if (pick_reg && found)
                begin
                    goal_reg <= pick_floor;
                end
                if (going_idle)
                begin
                    processing_reg <= 1'b0;
                    moving_reg     <= DIR_STAND;
                end
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            fl_reg  <= s_tdata[FLOOR_W-1:0];
            dir_reg <= s_tdata[FLOOR_W +: DIR_W];
        end
        if (cmd.init_a || cmd.init_b)
        begin
            scan_reg <= {1'b0, present_reg};
        end
        else if (cmd.step)
        begin
            scan_reg <= pass_up_reg ? (scan_reg + SCAN_W'(1)) : scan_m1;
        end
        if (cmd.step && req_hit)
        begin
            if (pass_b_reg)
            begin
                b_floor_reg <= scan_reg[FLOOR_W-1:0];
            end
            else
            begin
                a_floor_reg <= scan_reg[FLOOR_W-1:0];
            end
        end
        if (cmd.finish)
        begin
            m_data_reg <= {2'b00, bad_reg, busy, present_reg, served, stop_reg, target, tv};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* rtl/elevator_floor_dispatcher.sv */
// Top level of the elevator floor dispatcher: controller plus datapath.
//
//  channel   handshake          payload
//  cfg       cfg_we             cfg_wdata = floor_count
//  s (in)    s_tvalid/s_tready  s_tuser = operation; s_tdata = floor_number, travel_direction
//  m (out)   m_tvalid/m_tready  m_tdata = target_valid .. bad_request, one word per event
//
//  An event that needs no scan passes the apply and finish states before the next ready.
//  A scan walks the request map one floor per cycle in two passes, each starting at the
//  present floor: first in the travel direction (down when standing), then the other way.
//  Reset clears the request map and returns the cabin to floor 1, standing, in standby.
//  The result word sits in an output register; a stalled m_tready holds the next
//  result in the finish step until the register frees.
module elevator_floor_dispatcher (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [efd_pkg::FLOOR_W-1:0]   cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [5:0] floor_number, [7:6] travel_direction
    input  logic [efd_pkg::IN_W-1:0]      s_tdata,
    // [1:0] operation
    input  logic [efd_pkg::OP_W-1:0]      s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] target_valid, [6:1] target_floor, [7] served_valid, [13:8] served_floor,
    // [19:14] shown_floor, [20] busy_res, [21] bad_request, [23:22] zero
    output logic [efd_pkg::OUT_W-1:0]     m_tdata
);
    import efd_pkg::*;

    efd_cmd_t  cmd;
    efd_stat_t stat;

    efd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    efd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

/* rtl/efd_checker.sv */
// Port-level checker for the elevator floor dispatcher, bound to the top level.
module efd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cfg_we,
    input logic [efd_pkg::FLOOR_W-1:0]   cfg_wdata,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [efd_pkg::IN_W-1:0]      s_tdata,
    input logic [efd_pkg::OP_W-1:0]      s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [efd_pkg::OUT_W-1:0]     m_tdata
);
    import efd_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an event is in work");

    a_target_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[6:1] != '0)
        else $error("target floor is zero");

    a_bad_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[21] |-> !m_tdata[0] && !m_tdata[7])
        else $error("ignored event issued a target or served a floor");

    a_served_shown: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[7] |-> m_tdata[13:8] == m_tdata[19:14]
                                   && (m_tdata[0] || !m_tdata[20]))
        else $error("served floor differs from shown floor or busy without target");

endmodule

bind elevator_floor_dispatcher efd_checker u_efd_checker (.*);

/* test/tb.sv */
// Self-checking testbench for the elevator floor dispatcher: directed and random event streams.
module tb;
    import efd_pkg::*;

    localparam int LIMIT       = 1_000_000;
    localparam int SETTLE      = 80;
    localparam int IDLE_PCT    = 27;
    localparam int PHASE_ITEMS = 165;
    localparam int NUM_PHASES  = 10;
    localparam int COUNT_SET [NUM_PHASES] = '{32, 1, 0, 63, 7, 2, 20, 32, 45, 12};
    localparam int CALM_PHASE  = 3;

    localparam logic [DIR_W-1:0] DIR_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]         pad;
        logic               bad;
        logic               busy;
        logic [FLOOR_W-1:0] shown;
        logic [FLOOR_W-1:0] served_floor;
        logic               served;
        logic [FLOOR_W-1:0] target;
        logic               target_valid;
    } result_word_t;

    class floor_scoreboard;
        logic [FLOOR_W-1:0]    count;
        logic [MAX_FLOORS-1:0] req_map;
        logic [FLOOR_W-1:0]    present;
        logic [FLOOR_W-1:0]    goal;
        logic [DIR_W-1:0]      direction;
        logic                  busy;
        result_word_t          expected_words [$];
        int                    errors;
        int                    checked;
        int                    targets;
        int                    served;
        int                    flagged;

        function new();
            count     = COUNT_RST;
            req_map   = '0;
            present   = FLOOR_RST;
            goal      = FLOOR_RST;
            direction = DIR_STAND;
            busy      = 1'b0;
            errors    = 0;
            checked   = 0;
            targets   = 0;
            served    = 0;
            flagged   = 0;
        endfunction

        function void set_count(logic [FLOOR_W-1:0] value);
            count = value;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function int eff_count();
            if (count == 0)
                return 1;
            if (int'(count) > MAX_FLOORS)
                return MAX_FLOORS;
            return int'(count);
        endfunction

        function bit is_requested(int f);
            if (f < 1 || f > eff_count())
                return 1'b0;
            return req_map[f-1];
        endfunction

        function bit scan_toward(bit up);
            int n;
            int i;
            n = eff_count();
            i = int'(present);
            while (i >= 1 && i <= n)
            begin
                if (is_requested(i))
                begin
                    goal = FLOOR_W'(i);
                    return 1'b1;
                end
                i = up ? i + 1 : i - 1;
            end
            return 1'b0;
        endfunction

        function bit pick_nearest();
            int n;
            int lo;
            int hi;
            bit found_lo;
            bit found_hi;
            n = eff_count();
            lo = 0;
            hi = 0;
            found_lo = 1'b0;
            found_hi = 1'b0;
            for (int i = int'(present); i >= 1 && !found_lo; i--)
                if (is_requested(i))
                begin
                    lo = i;
                    found_lo = 1'b1;
                end
            for (int i = int'(present); i <= n && !found_hi; i++)
                if (is_requested(i))
                begin
                    hi = i;
                    found_hi = 1'b1;
                end
            if (!found_lo && !found_hi)
                return 1'b0;
            if (found_lo && found_hi)
                goal = ((int'(present) - lo) < (hi - int'(present)))
                     ? FLOOR_W'(lo) : FLOOR_W'(hi);
            else
                goal = found_lo ? FLOOR_W'(lo) : FLOOR_W'(hi);
            return 1'b1;
        endfunction

        function bit pick_next();
            bit up;
            if (direction == DIR_STAND)
                return pick_nearest();
            up = (direction != DIR_DOWN);
            if (scan_toward(up))
                return 1'b1;
            return scan_toward(!up);
        endfunction

        function bit floor_ok(logic [FLOOR_W-1:0] f);
            return f >= 1 && int'(f) <= eff_count();
        endfunction

        function void note_event(op_t op, logic [FLOOR_W-1:0] f, logic [DIR_W-1:0] d);
            result_word_t want;
            want = '0;
            case (op)
                OP_REQUEST:
                begin
                    if (!floor_ok(f))
                        want.bad = 1'b1;
                    else
                    begin
                        busy = 1'b1;
                        req_map[f-1] = 1'b1;
                        void'(pick_next());
                        want.target_valid = 1'b1;
                    end
                end
                OP_STOP:
                begin
                    if (busy)
                    begin
                        present = goal;
                        if (present >= 1 && int'(present) <= MAX_FLOORS)
                            req_map[present-1] = 1'b0;
                        want.served = 1'b1;
                        want.served_floor = present;
                        if (pick_next())
                            want.target_valid = 1'b1;
                        else
                        begin
                            busy = 1'b0;
                            direction = DIR_STAND;
                        end
                    end
                end
                OP_POSITION:
                begin
                    if (!floor_ok(f))
                        want.bad = 1'b1;
                    else
                        present = f;
                end
                default:
                    direction = (d == DIR_UP || d == DIR_DOWN) ? d : DIR_STAND;
            endcase
            want.target = goal;
            want.shown  = present;
            want.busy   = busy;
            targets += want.target_valid;
            served  += want.served;
            flagged += want.bad;
            expected_words.insert(expected_words.size(), want);
        endfunction

        function void check_word(logic [OUT_W-1:0] word);
            result_word_t got;
            result_word_t want;
            got = word;
            checked++;
            if (expected_words.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word %h", word);
                return;
            end
            want = expected_words.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch at word %0d", checked);
                    $display(
                        "  exp tv=%0d tgt=%0d sv=%0d sf=%0d shown=%0d busy=%0d bad=%0d pad=%0d",
                        want.target_valid, want.target, want.served, want.served_floor,
                        want.shown, want.busy, want.bad, want.pad);
                    $display(
                        "  got tv=%0d tgt=%0d sv=%0d sf=%0d shown=%0d busy=%0d bad=%0d pad=%0d",
                        got.target_valid, got.target, got.served, got.served_floor,
                        got.shown, got.busy, got.bad, got.pad);
                end
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [FLOOR_W-1:0] cfg_wdata = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata = '0;
    logic [OP_W-1:0]    s_tuser = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_W-1:0]   m_tdata;

    floor_scoreboard sb = new();
    bit              calm = 1'b0;
    int              sent = 0;
    int              cycle_count = 0;

    always #5 clk = ~clk;

    elevator_floor_dispatcher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata);
            m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_word(op_t op, int f, int d);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {DIR_W'(d), FLOOR_W'(f)};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_event(op, FLOOR_W'(f), DIR_W'(d));
        sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_count(int value);
        cfg_we    <= 1'b1;
        cfg_wdata <= FLOOR_W'(value);
        @(posedge clk);
        sb.set_count(FLOOR_W'(value));
        cfg_we    <= 1'b0;
    endtask

    function automatic int bad_floor(int eff);
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(eff + 1, 63);
    endfunction

    task automatic random_events(int n);
        op_t op;
        int  f;
        int  d;
        int  eff;
        int  r;
        for (int k = 0; k < n; k++)
        begin
            eff = sb.eff_count();
            r = $urandom_range(0, 99);
            f = $urandom_range(0, 63);
            d = $urandom_range(0, 3);
            if (r < 35)
            begin
                op = OP_REQUEST;
                f = ($urandom_range(0, 99) >= 12) ? $urandom_range(1, eff) : bad_floor(eff);
            end
            else if (r < 65)
                op = OP_STOP;
            else if (r < 80)
            begin
                op = OP_POSITION;
                f = ($urandom_range(0, 99) >= 15) ? $urandom_range(1, eff) : bad_floor(eff);
            end
            else
            begin
                op = OP_DIRECTION;
                if ($urandom_range(0, 99) < 70)
                begin
                    if (sb.goal > sb.present)
                        d = DIR_UP;
                    else if (sb.goal < sb.present)
                        d = DIR_DOWN;
                    else
                        d = DIR_STAND;
                end
            end
            send_word(op, f, d);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(OP_REQUEST, 0, DIR_UP);
        send_word(OP_REQUEST, 33, DIR_DOWN);
        send_word(OP_STOP, 63, DIR_UNUSED);
        send_word(OP_POSITION, 0, DIR_STAND);
        send_word(OP_POSITION, 32, DIR_UP);
        send_word(OP_REQUEST, 32, DIR_STAND);
        send_word(OP_STOP, 17, DIR_DOWN);
        send_word(OP_POSITION, 10, DIR_STAND);
        send_word(OP_REQUEST, 8, DIR_STAND);
        send_word(OP_REQUEST, 12, DIR_UNUSED);
        send_word(OP_DIRECTION, 45, DIR_UP);
        send_word(OP_REQUEST, 3, DIR_STAND);
        send_word(OP_DIRECTION, 0, DIR_DOWN);
        send_word(OP_REQUEST, 20, DIR_STAND);
        send_word(OP_DIRECTION, 63, DIR_UNUSED);
        send_word(OP_STOP, 0, DIR_STAND);
        send_word(OP_STOP, 0, DIR_STAND);
        send_word(OP_STOP, 0, DIR_STAND);
        send_word(OP_STOP, 0, DIR_STAND);
        send_word(OP_REQUEST, 30, DIR_STAND);
        send_word(OP_POSITION, 25, DIR_STAND);
        wait_drained();

        write_count(10);
        send_word(OP_DIRECTION, 0, DIR_UP);
        send_word(OP_REQUEST, 4, DIR_STAND);
        send_word(OP_POSITION, 11, DIR_STAND);
        send_word(OP_STOP, 0, DIR_STAND);
        send_word(OP_POSITION, 10, DIR_STAND);
        send_word(OP_REQUEST, 1, DIR_STAND);
        send_word(OP_STOP, 0, DIR_STAND);
        send_word(OP_STOP, 0, DIR_STAND);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_count(COUNT_SET[p]);
            calm = (p == CALM_PHASE);
            random_events(PHASE_ITEMS);
            wait_drained();
        end

        $display("Sent %0d events over %0d floor-count settings (0 to 63, incl. over-range).",
            sent, NUM_PHASES + 2);
        $display("Checked %0d result words: %0d targets, %0d arrivals served, %0d flagged bad.",
            sb.checked, sb.targets, sb.served, sb.flagged);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d mismatches, %0d results outstanding", sb.errors, sb.pending());
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
